/* src/gtrt_pkg.sv */
`timescale 1ns / 1ps

package gtrt_pkg;

    localparam int ADDR_W = 64;
    localparam int PORT_W = 8;

    typedef logic [2:0] status_t;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_BAD_KIND  = 3'd1;
    localparam status_t ST_EXISTS    = 3'd2;
    localparam status_t ST_FULL      = 3'd3;
    localparam status_t ST_NOT_FOUND = 3'd4;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    localparam logic [1:0] KIND_DOORBELL = 2'd0;
    localparam logic [1:0] KIND_MEMORY   = 2'd1;
    localparam logic [1:0] KIND_IO       = 2'd2;
    localparam logic [1:0] KIND_OTHER    = 2'd3;

    typedef struct packed {
        logic              lookup;
        logic              tbl;
        logic              bad_kind;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] len;
        logic [ADDR_W-1:0] key;
        logic [PORT_W-1:0] port;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] len;
        logic [ADDR_W-1:0] key;
        logic [PORT_W-1:0] port;
    } ent_t;

endpackage

/* src/gtrt_front.sv */
`timescale 1ns / 1ps

module gtrt_front #(
    parameter int HAS_IO_TABLE = 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    func,
    input  logic [1:0]              trap_kind,
    input  logic [63:0]             guest_addr,
    input  logic [63:0]             range_len,
    input  logic [63:0]             user_key,
    input  logic [7:0]              port_id,
    output logic                    push_valid,
    input  logic                    push_ready,
    output gtrt_pkg::cmd_t          push_cmd
);
    import gtrt_pkg::*;

    logic vld_reg;
    logic vld_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;
    logic tbl;
    logic bad;

    always_comb
    begin
        tbl = 1'b0;
        bad = 1'b0;
        unique case (trap_kind) inside
            KIND_DOORBELL, KIND_MEMORY:
            begin
                tbl = 1'b0;
            end
            KIND_IO:
            begin
                tbl = 1'b1;
                bad = (HAS_IO_TABLE == 0);
            end
            default:
            begin
                bad = 1'b1;
            end
        endcase
    end

    assign in_ready   = !vld_reg || push_ready;
    assign push_valid = vld_reg;
    assign push_cmd   = cmd_reg;

    always_comb
    begin
        vld_next = vld_reg;
        cmd_next = cmd_reg;
        if (push_ready)
        begin
            vld_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            vld_next          = 1'b1;
            cmd_next.lookup   = (func == FUNC_LOOKUP);
            cmd_next.tbl      = tbl;
            cmd_next.bad_kind = bad;
            cmd_next.addr     = guest_addr;
            cmd_next.len      = range_len;
            cmd_next.key      = user_key;
            cmd_next.port     = port_id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

/* src/gtrt_queue.sv */
`timescale 1ns / 1ps

module gtrt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  gtrt_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output gtrt_pkg::cmd_t pop_cmd
);
    import gtrt_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    logic       pop;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* src/gtrt_back.sv */
`timescale 1ns / 1ps

module gtrt_back #(
    parameter int ENTRIES_PER_TABLE = 16,
    parameter int HAS_IO_TABLE      = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_pop,
    input  gtrt_pkg::cmd_t    cmd,
    output logic              out_valid,
    input  logic              out_ready,
    output gtrt_pkg::status_t status,
    output logic [63:0]       hit_start,
    output logic [63:0]       hit_len,
    output logic [63:0]       hit_key,
    output logic [7:0]        hit_port
);
    import gtrt_pkg::*;

    localparam int SLOTS = (HAS_IO_TABLE != 0) ? 2 * ENTRIES_PER_TABLE : ENTRIES_PER_TABLE;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(ENTRIES_PER_TABLE + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    ent_t            mem [SLOTS];
    ent_t            rdata_reg;
    logic [1:0]      state_reg;
    logic [1:0]      state_next;
    cmd_t            cmd_reg;
    cmd_t            cmd_next;
    logic [CW-1:0]   issue_reg;
    logic [CW-1:0]   issue_next;
    logic            rd_vld_reg;
    logic            rd_vld_next;
    logic            dup_reg;
    logic            dup_next;
    logic            found_reg;
    logic            found_next;
    ent_t            best_reg;
    ent_t            best_next;
    logic [CW-1:0]   cnt_reg [2];
    logic [CW-1:0]   cnt_next [2];
    logic            out_valid_reg;
    logic            out_valid_next;
    status_t         status_reg;
    status_t         status_next;
    ent_t            hit_reg;
    ent_t            hit_next;

    logic [CW-1:0]   tbl_cnt;
    logic [SW-1:0]   base;
    logic [SW-1:0]   raddr;
    logic [SW-1:0]   waddr;
    logic            issue_en;
    logic            out_free;
    logic            mem_we;
    logic            tbl_full;
    logic            hit;
    logic [63:0]     offset;
    ent_t            wdata;

    assign tbl_cnt  = cnt_reg[cmd_reg.tbl];
    assign base     = cmd_reg.tbl ? SW'(ENTRIES_PER_TABLE) : '0;
    assign raddr    = base + SW'(issue_reg);
    assign waddr    = base + SW'(tbl_cnt);
    assign issue_en = (state_reg == S_SCAN) && (issue_reg < tbl_cnt);
    assign out_free = !out_valid_reg || out_ready;
    assign tbl_full = (tbl_cnt == CW'(ENTRIES_PER_TABLE));
    assign offset   = cmd_reg.addr - best_reg.start;
    assign hit      = found_reg && (offset < best_reg.len);
    assign cmd_pop  = (state_reg == S_IDLE) && cmd_valid;
    assign mem_we   = (state_reg == S_FINISH) && out_free && !cmd_reg.bad_kind
                      && !cmd_reg.lookup && !dup_reg && !tbl_full;

    assign wdata.start = cmd_reg.addr;
    assign wdata.len   = cmd_reg.len;
    assign wdata.key   = cmd_reg.key;
    assign wdata.port  = cmd_reg.port;

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign hit_start = hit_reg.start;
    assign hit_len   = hit_reg.len;
    assign hit_key   = hit_reg.key;
    assign hit_port  = hit_reg.port;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        issue_next     = issue_reg;
        rd_vld_next    = issue_en;
        dup_next       = dup_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        hit_next       = hit_reg;

        if (issue_en)
        begin
            issue_next = issue_reg + CW'(1);
        end

        if (rd_vld_reg)
        begin
            if (rdata_reg.start == cmd_reg.addr)
            begin
                dup_next = 1'b1;
            end
            if ((rdata_reg.start <= cmd_reg.addr)
                && (!found_reg || (rdata_reg.start > best_reg.start)))
            begin
                found_next = 1'b1;
                best_next  = rdata_reg;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next   = cmd;
                    issue_next = '0;
                    dup_next   = 1'b0;
                    found_next = 1'b0;
                    state_next = cmd.bad_kind ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!issue_en && !rd_vld_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = '0;
                    state_next     = S_IDLE;
                    if (cmd_reg.bad_kind)
                    begin
                        status_next = ST_BAD_KIND;
                    end
                    else if (cmd_reg.lookup)
                    begin
                        status_next = hit ? ST_OK : ST_NOT_FOUND;
                        if (hit)
                        begin
                            hit_next = best_reg;
                        end
                    end
                    else if (dup_reg)
                    begin
                        status_next = ST_EXISTS;
                    end
                    else if (tbl_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        status_next           = ST_OK;
                        cnt_next[cmd_reg.tbl] = tbl_cnt + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_vld_reg    <= 1'b0;
            cnt_reg[0]    <= '0;
            cnt_reg[1]    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_vld_reg    <= rd_vld_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        issue_reg  <= issue_next;
        dup_reg    <= dup_next;
        found_reg  <= found_next;
        best_reg   <= best_next;
        status_reg <= status_next;
        hit_reg    <= hit_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg[0] <= CW'(ENTRIES_PER_TABLE)) && (cnt_reg[1] <= CW'(ENTRIES_PER_TABLE)))
        else $error("table fill count above capacity");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != ST_OK)) |-> (hit_reg == '0))
        else $error("hit fields set on a failed result");

    a_scan_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !cmd_reg.bad_kind)
        else $error("scan started for an invalid kind");

    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (out_valid_reg && (status_reg == ST_OK)))
        else $error("table write without an ok result");

endmodule

/* src/guest_trap_range_table_top.sv */
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// in        in_valid / in_ready    func, trap_kind, guest_addr, range_len, user_key, port_id
// out       out_valid / out_ready  status, hit_start, hit_len, hit_key, hit_port
//
// An item passes through the front register and then the queue before the back engine scans
// the selected table: one memory read per stored entry through a single read port with
// registered data. An empty table issues no read, and an invalid kind skips the scan.
// Reset clears the fill counts but not the stored entries; entries beyond the count are never used.
// The front keeps accepting while the back scans, until the queue fills; out stalls hold the
// finished result in the output register.

module guest_trap_range_table_top #(
    parameter int ENTRIES_PER_TABLE = 16,
    parameter int HAS_IO_TABLE      = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              func,
    input  logic [1:0]        trap_kind,
    input  logic [63:0]       guest_addr,
    input  logic [63:0]       range_len,
    input  logic [63:0]       user_key,
    input  logic [7:0]        port_id,
    output logic              out_valid,
    input  logic              out_ready,
    output gtrt_pkg::status_t status,
    output logic [63:0]       hit_start,
    output logic [63:0]       hit_len,
    output logic [63:0]       hit_key,
    output logic [7:0]        hit_port
);
    import gtrt_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    gtrt_front #(
        .HAS_IO_TABLE (HAS_IO_TABLE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .trap_kind  (trap_kind),
        .guest_addr (guest_addr),
        .range_len  (range_len),
        .user_key   (user_key),
        .port_id    (port_id),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    gtrt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    gtrt_back #(
        .ENTRIES_PER_TABLE (ENTRIES_PER_TABLE),
        .HAS_IO_TABLE      (HAS_IO_TABLE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd_pop   (pop_ready),
        .cmd       (pop_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .hit_start (hit_start),
        .hit_len   (hit_len),
        .hit_key   (hit_key),
        .hit_port  (hit_port)
    );

endmodule
